[rtl/spe_pkg.sv]
// ----------------------------------------------------------------------------
// spe_pkg
// Shared widths, fixed-point constants, stage payload types and the
// elaboration-time builders for the sine and frequency tables.
// ----------------------------------------------------------------------------
package spe_pkg;

  localparam int POS_W   = 11;
  localparam int DIM_W   = 9;
  localparam int DATA_W  = 16;
  localparam int FREQ_W  = 32;
  localparam int PHASE_W = 32;
  localparam int FRAC_W  = 22;
  localparam int QSIN_W  = 17;   // sin(pi/2) may round to 1.0 in Q0.16
  localparam int QIDX_W  = 9;
  localparam int QSIN_SEGS = 256;
  localparam int SUM_W   = DATA_W + 2;

  localparam int MODEL_WIDTH_DEF = 512;

  localparam logic [63:0] LN10000_Q30 = 64'd9889527671;
  localparam logic [63:0] LN2_Q30     = 64'd744261118;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] INV2PI_Q32  = 64'd683565276;
  localparam logic [63:0] ONE_Q30     = 64'd1073741824;

  localparam logic [PHASE_W-1:0] QUARTER_TURN = 32'h4000_0000;

  localparam logic signed [SUM_W-1:0] SUM_MAX = 18'sd32767;
  localparam logic signed [SUM_W-1:0] SUM_MIN = -18'sd32768;

  typedef logic [QSIN_W-1:0] qsin_rom_t [QSIN_SEGS+1];

  typedef struct packed {
    logic [PHASE_W-1:0]       phase;
    logic signed [DATA_W-1:0] embed;
  } spe_phase_t;

  typedef struct packed {
    logic [QSIN_W-1:0]        mag;
    logic                     neg;
    logic signed [DATA_W-1:0] embed;
  } spe_mag_t;

  // exp(-f), Q30, truncated Taylor series
  function automatic logic [63:0] exp_neg_q30(input logic [63:0] f);
    logic signed [63:0] acc;
    logic [63:0]        term;
    acc  = signed'(ONE_Q30);
    term = ONE_Q30;
    for (int j = 1; j <= 14; j++) begin
      term = ((term * f) >> 30) / 64'(j);
      if (j % 2 == 1) acc = acc - signed'(term);
      else            acc = acc + signed'(term);
    end
    return (acc < 0) ? 64'd0 : unsigned'(acc);
  endfunction

  // sin(x), Q30, truncated Taylor series
  function automatic logic [63:0] sin_q30(input logic [63:0] x);
    logic signed [63:0] acc;
    logic [63:0]        term;
    logic [63:0]        x2;
    acc  = signed'(x);
    term = x;
    x2   = (x * x) >> 30;
    for (int n = 1; n < 10; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) acc = acc - signed'(term);
      else            acc = acc + signed'(term);
    end
    return (acc < 0) ? 64'd0 : unsigned'(acc);
  endfunction

  function automatic qsin_rom_t build_qsin();
    qsin_rom_t   rom;
    logic [63:0] x;
    logic [63:0] s;
    for (int i = 0; i <= QSIN_SEGS; i++) begin
      x      = (64'(i) * HALF_PI_Q30) >> 8;
      s      = sin_q30(x);
      rom[i] = QSIN_W'((s + 64'd8192) >> 14);
    end
    return rom;
  endfunction

endpackage

[rtl/sinusoidal_position_encode_add.sv]
// ----------------------------------------------------------------------------
// sinusoidal_position_encode_add
// Adds the sinusoidal positional code of (position, dimension) to one
// Q4.12 embedding word and saturates the sum to 16 bits.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid_i / in_stall_o carry position_i, dim_index_i and
//   embed_value_i. Output channel: out_valid_o / out_stall_i carry sum_value_o.
//   A word moves at a rising edge where valid is high and stall is low.
//   Throughput: one word per cycle while out_stall_i is low. Five register stages
//   (frequency ROM read, phase multiply, sine table read, interpolation,
//   add/saturate) lie between an accepted input word and its result.
//   Even dimensions take the sine, odd ones the cosine; dimension pairs past
//   the frequency table use its last entry.
//   Reset clears all stage valid bits; the tables are constant and need no
//   loading, so words are taken right after reset.
//   When the receiver stalls, empty stages still fill; once every stage holds
//   a word, in_stall_o follows out_stall_i in the same cycle.
// ----------------------------------------------------------------------------
module sinusoidal_position_encode_add
  import spe_pkg::*;
#(
  parameter int MODEL_WIDTH = MODEL_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [POS_W-1:0]         position_i,
  input  logic [DIM_W-1:0]         dim_index_i,
  input  logic signed [DATA_W-1:0] embed_value_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] sum_value_o
);

  logic                     ph_valid, ph_stall;
  spe_phase_t               ph_data;
  logic                     sn_valid, sn_stall;
  spe_mag_t                 sn_data;
  logic                     out_valid_q;
  logic signed [DATA_W-1:0] sum_q;
  logic                     adv;
  logic [QSIN_W:0]          rnd;
  logic [QSIN_W-4:0]        code;
  logic signed [SUM_W-1:0]  code_s;
  logic signed [SUM_W-1:0]  sum_wide;
  logic signed [DATA_W-1:0] sum_d;

  spe_phase #(
    .MODEL_WIDTH (MODEL_WIDTH)
  ) u_phase (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (in_valid_i),
    .stall_o       (in_stall_o),
    .position_i    (position_i),
    .dim_index_i   (dim_index_i),
    .embed_value_i (embed_value_i),
    .valid_o       (ph_valid),
    .stall_i       (ph_stall),
    .data_o        (ph_data)
  );

  spe_sine u_sine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (ph_valid),
    .stall_o (ph_stall),
    .data_i  (ph_data),
    .valid_o (sn_valid),
    .stall_i (sn_stall),
    .data_o  (sn_data)
  );

  assign adv      = !out_valid_q || !out_stall_i;
  assign sn_stall = !adv;

  // Q0.16 magnitude to Q4.12, rounded
  always_comb begin
    rnd      = {1'b0, sn_data.mag} + (QSIN_W + 1)'(8);
    code     = rnd[QSIN_W:4];
    code_s   = sn_data.neg ? -signed'(SUM_W'(code)) : signed'(SUM_W'(code));
    sum_wide = SUM_W'(sn_data.embed) + code_s;
    if (sum_wide > SUM_MAX)      sum_d = SUM_MAX[DATA_W-1:0];
    else if (sum_wide < SUM_MIN) sum_d = SUM_MIN[DATA_W-1:0];
    else                         sum_d = sum_wide[DATA_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= sn_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && sn_valid) begin
      sum_q <= sum_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sum_value_o = sum_q;

  a_empty_accepts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> !in_stall_o)
    else $error("input stalled while output register is empty");

endmodule

[rtl/spe_phase.sv]
// ----------------------------------------------------------------------------
// spe_phase
// Two pipeline stages: frequency ROM lookup by dimension pair, then
// position times frequency (fractional turn) plus a quarter turn for cosine.
// ----------------------------------------------------------------------------
module spe_phase
  import spe_pkg::*;
#(
  parameter int MODEL_WIDTH = MODEL_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     stall_o,
  input  logic [POS_W-1:0]         position_i,
  input  logic [DIM_W-1:0]         dim_index_i,
  input  logic signed [DATA_W-1:0] embed_value_i,
  output logic                     valid_o,
  input  logic                     stall_i,
  output spe_phase_t               data_o
);

  localparam int FREQ_DEPTH = MODEL_WIDTH / 2;
  localparam int KW = (FREQ_DEPTH > 1) ? $clog2(FREQ_DEPTH) : 1;

  logic [FREQ_W-1:0] freq_rom [FREQ_DEPTH];

  for (genvar k = 0; k < FREQ_DEPTH; k++) begin : g_freq
    localparam logic [63:0] X   = (64'(k) * 64'd2 * LN10000_Q30) / MODEL_WIDTH;
    localparam logic [63:0] N   = X / LN2_Q30;
    localparam logic [63:0] F   = X - N * LN2_Q30;
    localparam logic [63:0] E   = exp_neg_q30(F);
    localparam logic [63:0] SH  = 64'd30 + N;
    localparam logic [63:0] VAL = (SH > 64'd62) ? 64'd0 :
                                  ((E * INV2PI_Q32 + (64'd1 << (SH - 64'd1))) >> SH);
    assign freq_rom[k] = VAL[FREQ_W-1:0];
  end

  logic                     v1_q, v2_q;
  logic                     adv1, adv2;
  logic [DIM_W-2:0]         dim_k;
  logic [KW-1:0]            rom_idx;
  logic [FREQ_W-1:0]        freq_q;
  logic [POS_W-1:0]         pos_q;
  logic                     odd_q;
  logic signed [DATA_W-1:0] embed1_q;
  logic [POS_W+FREQ_W-1:0]  prod;
  logic [PHASE_W-1:0]       phase_d;
  spe_phase_t               out_q;

  assign adv2    = !v2_q || !stall_i;
  assign adv1    = !v1_q || adv2;
  assign stall_o = !adv1;

  // dimension pairs beyond the table use the last entry
  assign dim_k = dim_index_i[DIM_W-1:1];
  always_comb begin
    if (32'(dim_k) >= FREQ_DEPTH) rom_idx = KW'(FREQ_DEPTH - 1);
    else                          rom_idx = KW'(dim_k);
  end

  assign prod    = POS_W'(pos_q) * freq_q;
  assign phase_d = prod[PHASE_W-1:0] + (odd_q ? QUARTER_TURN : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= valid_i;
      if (adv2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && valid_i) begin
      freq_q   <= freq_rom[rom_idx];
      pos_q    <= position_i;
      odd_q    <= dim_index_i[0];
      embed1_q <= embed_value_i;
    end
    if (adv2 && v1_q) begin
      out_q.phase <= phase_d;
      out_q.embed <= embed1_q;
    end
  end

  assign valid_o = v2_q;
  assign data_o  = out_q;

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && stall_i |=> v2_q && $stable(out_q))
    else $error("phase stage lost or changed a stalled word");

endmodule

[rtl/spe_sine.sv]
// ----------------------------------------------------------------------------
// spe_sine
// Two pipeline stages: quadrant fold and quarter-wave table read, then
// linear interpolation between neighboring table entries.
// ----------------------------------------------------------------------------
module spe_sine
  import spe_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       stall_o,
  input  spe_phase_t data_i,
  output logic       valid_o,
  input  logic       stall_i,
  output spe_mag_t   data_o
);

  localparam qsin_rom_t QSIN = build_qsin();
  localparam int PROD_W = QSIN_W + FRAC_W + 1;

  logic                     v1_q, v2_q;
  logic                     adv1, adv2;
  logic [1:0]               quad;
  logic [30:0]              off;
  logic [QIDX_W-1:0]        idx, nxt;
  logic [QSIN_W-1:0]        lo_q, hi_q;
  logic [FRAC_W-1:0]        frac_q;
  logic                     neg_q;
  logic signed [DATA_W-1:0] embed_q;
  logic [QSIN_W-1:0]        diff;
  logic [QSIN_W+FRAC_W:0]   prod;
  logic [QSIN_W-1:0]        interp;
  spe_mag_t                 out_q;

  assign adv2    = !v2_q || !stall_i;
  assign adv1    = !v1_q || adv2;
  assign stall_o = !adv1;

  // odd quadrants run the quarter wave backward
  assign quad = data_i.phase[PHASE_W-1:PHASE_W-2];
  always_comb begin
    if (quad[0]) off = 31'h4000_0000 - {1'b0, data_i.phase[29:0]};
    else         off = {1'b0, data_i.phase[29:0]};
    idx = off[30:FRAC_W];
    if (idx < QIDX_W'(QSIN_SEGS)) nxt = idx + 1'b1;
    else                          nxt = QIDX_W'(QSIN_SEGS);
  end

  assign diff   = (hi_q < lo_q) ? '0 : hi_q - lo_q;
  assign prod   = PROD_W'(diff) * PROD_W'(frac_q) + PROD_W'(1 << (FRAC_W - 1));
  assign interp = prod[FRAC_W +: QSIN_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= valid_i;
      if (adv2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && valid_i) begin
      lo_q    <= QSIN[idx];
      hi_q    <= QSIN[nxt];
      frac_q  <= off[FRAC_W-1:0];
      neg_q   <= quad[1];
      embed_q <= data_i.embed;
    end
    if (adv2 && v1_q) begin
      out_q.mag   <= lo_q + interp;
      out_q.neg   <= neg_q;
      out_q.embed <= embed_q;
    end
  end

  assign valid_o = v2_q;
  assign data_o  = out_q;

  a_mag_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> out_q.mag <= 17'd65536)
    else $error("sine magnitude above one");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && stall_i |=> v2_q && $stable(out_q))
    else $error("sine stage lost or changed a stalled word");

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams (position, dimension, embedding) words through the positional
// encoder and checks every sum against an integer model of the sine/cosine
// code or a hand-typed sum, under several sender/receiver idling mixes and one long output hold.
// ----------------------------------------------------------------------------
module testbench
  import spe_pkg::*;
;

  localparam int IDLE_LIMIT  = 2000;
  localparam int FREQ_DEPTH  = MODEL_WIDTH_DEF / 2;
  localparam int WAVE_SEGS   = 256;
  localparam int MAX_REPORTS = 20;

  localparam longint unsigned K_LN10000 = 64'd9889527671;
  localparam longint unsigned K_LN2     = 64'd744261118;
  localparam longint unsigned K_HALF_PI = 64'd1686629713;
  localparam longint unsigned K_INV2PI  = 64'd683565276;
  localparam longint unsigned K_ONE     = 64'd1073741824;

  typedef struct packed {
    logic [POS_W-1:0]  position;
    logic [DIM_W-1:0]  dim;
    logic [DATA_W-1:0] embed;
    logic              typed;
    logic [DATA_W-1:0] want;
  } stim_row_t;

  typedef struct {
    logic [POS_W-1:0]         position;
    logic [DIM_W-1:0]         dim;
    logic signed [DATA_W-1:0] embed;
    logic signed [DATA_W-1:0] sum;
  } cell_t;

  // rows with typed=1 carry a sum that is obvious: phase zero or a quarter turn
  localparam stim_row_t DIRECTED [24] = '{
    '{11'd0,    9'd0,   16'h0000, 1'b1, 16'h0000},
    '{11'd0,    9'd1,   16'h0000, 1'b1, 16'h1000},
    '{11'd0,    9'd0,   16'h7FFF, 1'b1, 16'h7FFF},
    '{11'd0,    9'd1,   16'h7FFF, 1'b1, 16'h7FFF},
    '{11'd0,    9'd0,   16'h8000, 1'b1, 16'h8000},
    '{11'd0,    9'd1,   16'h8000, 1'b1, 16'h9000},
    '{11'd0,    9'd511, 16'h0064, 1'b1, 16'h1064},
    '{11'd0,    9'd510, 16'hFF9C, 1'b1, 16'hFF9C},
    '{11'd2047, 9'd0,   16'h0000, 1'b0, 16'h0000},
    '{11'd2047, 9'd1,   16'h0000, 1'b0, 16'h0000},
    '{11'd2047, 9'd510, 16'h0000, 1'b0, 16'h0000},
    '{11'd2047, 9'd511, 16'h0000, 1'b0, 16'h0000},
    '{11'd1,    9'd0,   16'h7FFF, 1'b0, 16'h0000},
    '{11'd1,    9'd1,   16'h8000, 1'b0, 16'h0000},
    '{11'd1023, 9'd255, 16'h3039, 1'b0, 16'h0000},
    '{11'd1024, 9'd256, 16'hCFC7, 1'b0, 16'h0000},
    '{11'd2047, 9'd0,   16'h7FFF, 1'b0, 16'h0000},
    '{11'd2047, 9'd1,   16'h8000, 1'b0, 16'h0000},
    '{11'd6,    9'd0,   16'h0000, 1'b0, 16'h0000},
    '{11'd3,    9'd0,   16'h0000, 1'b0, 16'h0000},
    '{11'd5,    9'd0,   16'h8000, 1'b0, 16'h0000},
    '{11'd4,    9'd1,   16'h0000, 1'b0, 16'h0000},
    '{11'd1,    9'd2,   16'h0000, 1'b0, 16'h0000},
    '{11'd2047, 9'd2,   16'h1234, 1'b0, 16'h0000}
  };

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic [POS_W-1:0]         position_i = '0;
  logic [DIM_W-1:0]         dim_index_i = '0;
  logic signed [DATA_W-1:0] embed_value_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [DATA_W-1:0] sum_value_o;

  // travels with the word: a hand-typed sum overrides the model
  logic                     want_typed = 1'b0;
  logic signed [DATA_W-1:0] want_sum = '0;

  logic [31:0] freq_turns [FREQ_DEPTH];
  logic [31:0] quarter_wave [WAVE_SEGS+1];

  cell_t pending_sums [$];
  cell_t entry;

  int gap_pct = 0;
  int stall_pct = 0;
  int hold_len = 0;
  int idle_cycles = 0;
  int errors = 0;
  int words_in = 0;
  int sums_checked = 0;
  int saturated = 0;
  int cosines = 0;
  bit moved;

  sinusoidal_position_encode_add u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .position_i   (position_i),
    .dim_index_i  (dim_index_i),
    .embed_value_i(embed_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sum_value_o  (sum_value_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // exp(-f) in Q30, truncated Taylor terms
  function automatic longint unsigned neg_exp_series(longint unsigned f);
    longint          acc;
    longint unsigned term;
    acc  = longint'(K_ONE);
    term = K_ONE;
    for (int j = 1; j <= 14; j++) begin
      term = ((term * f) >> 30) / longint'(j);
      if (j % 2 == 1) acc = acc - longint'(term);
      else            acc = acc + longint'(term);
    end
    return (acc < 0) ? 64'd0 : longint'(acc);
  endfunction

  // sin(x) in Q30, truncated Taylor terms
  function automatic longint unsigned sin_series(longint unsigned x);
    longint          acc;
    longint unsigned term;
    longint unsigned x2;
    acc  = longint'(x);
    term = x;
    x2   = (x * x) >> 30;
    for (int n = 1; n < 10; n++) begin
      term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) acc = acc - longint'(term);
      else            acc = acc + longint'(term);
    end
    return (acc < 0) ? 64'd0 : longint'(acc);
  endfunction

  // Q4.12 sine of a 32-bit phase in turns, quarter-wave table + lerp
  function automatic int wave_code(logic [31:0] phase);
    logic [1:0]      quad;
    logic [31:0]     off;
    int              idx;
    int              nxt;
    longint unsigned frac;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned v;
    int              mag;
    quad = phase[31:30];
    off  = {2'b00, phase[29:0]};
    if (quad[0]) off = 32'h4000_0000 - off;
    idx  = int'(off >> 22);
    frac = longint'(off[21:0]);
    if (idx > WAVE_SEGS) idx = WAVE_SEGS;
    nxt = (idx < WAVE_SEGS) ? idx + 1 : WAVE_SEGS;
    lo  = longint'(quarter_wave[idx]);
    hi  = longint'(quarter_wave[nxt]);
    if (hi < lo) hi = lo;
    v   = lo + (((hi - lo) * frac + (64'd1 << 21)) >> 22);
    mag = int'((v + 8) >> 4);
    return quad[1] ? -mag : mag;
  endfunction

  function automatic logic signed [DATA_W-1:0] positional_sum(
    logic [POS_W-1:0] pos, logic [DIM_W-1:0] dim, logic signed [DATA_W-1:0] embed);
    int              k;
    logic [31:0]     phase;
    longint unsigned prod;
    int              total;
    k = int'(dim >> 1);
    if (k >= FREQ_DEPTH) k = FREQ_DEPTH - 1;
    prod  = longint'(pos) * longint'(freq_turns[k]);
    phase = prod[31:0];   // whole turns drop out
    if (dim[0]) phase = phase + 32'h4000_0000;
    total = int'(embed) + wave_code(phase);
    if (total > 32767)  total = 32767;
    if (total < -32768) total = -32768;
    return DATA_W'(total);
  endfunction

  task automatic offer_word(logic [POS_W-1:0] pos, logic [DIM_W-1:0] dim,
                            logic signed [DATA_W-1:0] embed, logic typed,
                            logic signed [DATA_W-1:0] want);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i    <= 1'b0;
      position_i    <= POS_W'($urandom);
      dim_index_i   <= DIM_W'($urandom);
      embed_value_i <= DATA_W'($urandom);
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    position_i    <= pos;
    dim_index_i   <= dim;
    embed_value_i <= embed;
    want_typed    <= typed;
    want_sum      <= want;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic run_phase(int count, int gaps, int stalls);
    logic [POS_W-1:0]  pos;
    logic [DIM_W-1:0]  dim;
    logic [DATA_W-1:0] embed;
    gap_pct   = gaps;
    stall_pct = stalls;
    repeat (count) begin
      case ($urandom_range(15))
        0:       pos = '0;
        1:       pos = '1;
        2, 3, 4: pos = POS_W'($urandom_range(15));
        default: pos = POS_W'($urandom_range(2047));
      endcase
      dim = DIM_W'($urandom_range(511));
      if ($urandom_range(15) == 0) dim = 9'd510 | DIM_W'($urandom_range(1));
      case ($urandom_range(7))
        0:       embed = 16'h7FFF - DATA_W'($urandom_range(4095));
        1:       embed = 16'h8000 + DATA_W'($urandom_range(4095));
        default: embed = DATA_W'($urandom_range(65535));
      endcase
      offer_word(pos, dim, embed, 1'b0, '0);
    end
  endtask

  // scoreboard and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      moved = 1'b0;
      if (in_valid_i && !in_stall_o) begin
        entry.position = position_i;
        entry.dim      = dim_index_i;
        entry.embed    = embed_value_i;
        entry.sum      = want_typed ? want_sum
                                    : positional_sum(position_i, dim_index_i, embed_value_i);
        pending_sums.push_back(entry);
        words_in++;
        if (dim_index_i[0]) cosines++;
        if (entry.sum == 16'sh7FFF || entry.sum == -16'sh8000) saturated++;
        moved = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        moved = 1'b1;
        if (pending_sums.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: unexpected sum_value %0d, expected none", $time, sum_value_o);
        end else begin
          entry = pending_sums.pop_front();
          sums_checked++;
          if (sum_value_o !== entry.sum) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: sum_value (pos %0d dim %0d embed %0d) expected %0d, actual %0d",
                       $time, entry.position, entry.dim, entry.embed, entry.sum,
                       sum_value_o);
          end
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no word moved for %0d cycles, %0d sums outstanding",
                 $time, idle_cycles, pending_sums.size());
        $display("sinusoidal_position_encode_add: mismatch");
        $finish;
      end
    end
  end

  // receiver: random stalls, plus one long hold when requested
  initial begin
    int n;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_len != 0) begin
        n = hold_len;
        hold_len = 0;
        repeat (n) begin
          out_stall_i <= 1'b1;
          @(posedge clk_i);
        end
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
        @(posedge clk_i);
      end
    end
  end

  initial begin
    longint unsigned x;
    longint unsigned n;
    longint unsigned f;
    longint unsigned e;
    longint unsigned sh;
    longint unsigned val;
    for (int k = 0; k < FREQ_DEPTH; k++) begin
      x  = (longint'(k) * 2 * K_LN10000) / longint'(MODEL_WIDTH_DEF);
      n  = x / K_LN2;
      f  = x - n * K_LN2;
      e  = neg_exp_series(f);
      sh = 30 + n;
      if (sh > 62) val = 0;
      else         val = (e * K_INV2PI + (64'd1 << (sh - 1))) >> sh;
      freq_turns[k] = val[31:0];
    end
    for (int i = 0; i <= WAVE_SEGS; i++) begin
      x = (longint'(i) * K_HALF_PI) >> 8;
      val = (sin_series(x) + 64'd8192) >> 14;
      quarter_wave[i] = val[31:0];
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIRECTED[r])
      offer_word(DIRECTED[r].position, DIRECTED[r].dim, DIRECTED[r].embed,
                 DIRECTED[r].typed, DIRECTED[r].want);

    run_phase(120, 0, 0);
    run_phase(120, 48, 0);
    run_phase(120, 0, 48);
    run_phase(120, 15, 15);
    // output held while input keeps coming: pipe fills, in_stall_o must rise
    hold_len = 64;
    run_phase(120, 0, 0);
    in_valid_i <= 1'b0;

    while (pending_sums.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);

    $display("%0d words in, %0d sums checked (%0d cosine, %0d saturated), errors %0d",
             words_in, sums_checked, cosines, saturated, errors);
    $display("idling mixes: none, sender 48%%, receiver 48%%, both 15%%, plus a 64-cycle hold");
    if (errors == 0) begin
      $display("sinusoidal_position_encode_add: match");
    end else begin
      $display("sinusoidal_position_encode_add: mismatch");
    end
    $finish;
  end

endmodule

[files.f]
rtl/spe_pkg.sv
rtl/spe_phase.sv
rtl/spe_sine.sv
rtl/sinusoidal_position_encode_add.sv
tb/testbench.sv
